FILE: src/mvrm_pkg.sv
// ----------------------------------------------------------------------------
// mvrm_pkg
// shared types, codes and constants of the multi-voice resampling mixer
// ----------------------------------------------------------------------------
package mvrm_pkg;

  localparam int VOICES_DEF       = 16;
  localparam int SAMPLE_WORDS_DEF = 65536;

  // operation codes carried in tuser
  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_VOLUME = 3'd2;
  localparam logic [2:0] OP_PITCH  = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  // configuration register indexes
  localparam int         CFG_IDX_W    = 8;
  localparam logic [7:0] CFG_MASTER_L = 8'd0;
  localparam logic [7:0] CFG_MASTER_R = 8'd1;

  localparam int IN_DATA_W  = 120;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 1;

  localparam logic [15:0] UNITY_GAIN = 16'd16384;
  localparam logic [15:0] UNITY_STEP = 16'd4096;

  // mix accumulator, 39-bit terms summed over up to 64 voices
  localparam int ACC_W = 46;

  typedef enum logic [4:0] {
    ST_NONE,
    ST_CAPTURE,
    ST_LOAD_WR,
    ST_START,
    ST_VOICE_RD,
    ST_CHECK,
    ST_SAMP0,
    ST_SAMP1,
    ST_MIX0,
    ST_MIX1,
    ST_MUL_L,
    ST_MUL_R,
    ST_WB,
    ST_NEXT,
    ST_DIVL_INIT,
    ST_DIVR_INIT,
    ST_DIV_RUN,
    ST_VOL_WB,
    ST_PITCH_WB,
    ST_FINISH
  } dp_step_t;

  typedef struct packed {
    dp_step_t step;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       cur_active;
    logic       past_end;
    logic       last_voice;
    logic       div_done;
    logic       slot_ok;
  } dp_sts_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] length;
    logic [27:0] position;
    logic [15:0] step;
    logic [31:0] cur_l;
    logic [31:0] cur_r;
    logic [15:0] goal_l;
    logic [15:0] goal_r;
    logic [31:0] ramp_l;
    logic [31:0] ramp_r;
  } voice_t;

  // input tdata layout, last member in the lowest bits
  typedef struct packed {
    logic [15:0]        pitch_step;
    logic [19:0]        fade_samples;
    logic [15:0]        target_right;
    logic [15:0]        target_left;
    logic [15:0]        sound_length;
    logic signed [15:0] sample_word;
    logic [15:0]        sample_address;
    logic [3:0]         voice_slot;
  } item_t;

endpackage

FILE: src/mvrm_ctrl.sv
// ----------------------------------------------------------------------------
// mvrm_ctrl
// operation sequencer of the mixer, drives the datapath step by step
// ----------------------------------------------------------------------------
module mvrm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output mvrm_pkg::dp_cmd_t cmd,
  input  mvrm_pkg::dp_sts_t sts
);
  import mvrm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_LD_WAIT, S_LD_WR, S_START,
    S_T_RD, S_T_CHK, S_T_A0W, S_T_S0, S_T_A1W, S_T_S1,
    S_T_MIX0, S_T_MIX1, S_T_MULL, S_T_MULR, S_T_WB, S_T_NEXT,
    S_V_RD, S_V_DIVL0, S_V_DIVL, S_V_DIVR0, S_V_DIVR, S_V_WB,
    S_P_RD, S_P_WB, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   fire;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign fire       = (state_r == S_FIN) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    cmd.step  = ST_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.step  = ST_CAPTURE;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_LOAD:   state_nxt = S_LD_WAIT;
          OP_START:  state_nxt = S_START;
          OP_VOLUME: state_nxt = sts.slot_ok ? S_V_RD : S_FIN;
          OP_PITCH:  state_nxt = sts.slot_ok ? S_P_RD : S_FIN;
          OP_TICK:   state_nxt = S_T_RD;
          default:   state_nxt = S_FIN;
        endcase
      end
      S_LD_WAIT: state_nxt = S_LD_WR;
      S_LD_WR: begin
        cmd.step  = ST_LOAD_WR;
        state_nxt = S_FIN;
      end
      S_START: begin
        cmd.step  = ST_START;
        state_nxt = S_FIN;
      end
      S_T_RD: begin
        cmd.step = ST_VOICE_RD;
        if (sts.cur_active) begin
          state_nxt = S_T_CHK;
        end else begin
          state_nxt = sts.last_voice ? S_FIN : S_T_NEXT;
        end
      end
      S_T_CHK: begin
        cmd.step = ST_CHECK;
        if (sts.past_end) begin
          state_nxt = sts.last_voice ? S_FIN : S_T_NEXT;
        end else begin
          state_nxt = S_T_A0W;
        end
      end
      S_T_A0W: state_nxt = S_T_S0;
      S_T_S0: begin
        cmd.step  = ST_SAMP0;
        state_nxt = S_T_A1W;
      end
      S_T_A1W: state_nxt = S_T_S1;
      S_T_S1: begin
        cmd.step  = ST_SAMP1;
        state_nxt = S_T_MIX0;
      end
      S_T_MIX0: begin
        cmd.step  = ST_MIX0;
        state_nxt = S_T_MIX1;
      end
      S_T_MIX1: begin
        cmd.step  = ST_MIX1;
        state_nxt = S_T_MULL;
      end
      S_T_MULL: begin
        cmd.step  = ST_MUL_L;
        state_nxt = S_T_MULR;
      end
      S_T_MULR: begin
        cmd.step  = ST_MUL_R;
        state_nxt = S_T_WB;
      end
      S_T_WB: begin
        cmd.step  = ST_WB;
        state_nxt = sts.last_voice ? S_FIN : S_T_NEXT;
      end
      S_T_NEXT: begin
        cmd.step  = ST_NEXT;
        state_nxt = S_T_RD;
      end
      S_V_RD: begin
        cmd.step  = ST_VOICE_RD;
        state_nxt = S_V_DIVL0;
      end
      S_V_DIVL0: begin
        cmd.step  = ST_DIVL_INIT;
        state_nxt = S_V_DIVL;
      end
      S_V_DIVL: begin
        cmd.step = ST_DIV_RUN;
        if (sts.div_done) state_nxt = S_V_DIVR0;
      end
      S_V_DIVR0: begin
        cmd.step  = ST_DIVR_INIT;
        state_nxt = S_V_DIVR;
      end
      S_V_DIVR: begin
        cmd.step = ST_DIV_RUN;
        if (sts.div_done) state_nxt = S_V_WB;
      end
      S_V_WB: begin
        cmd.step  = ST_VOL_WB;
        state_nxt = S_FIN;
      end
      S_P_RD: begin
        cmd.step  = ST_VOICE_RD;
        state_nxt = S_P_WB;
      end
      S_P_WB: begin
        cmd.step  = ST_PITCH_WB;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (fire) begin
          cmd.step  = ST_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (fire) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule

FILE: src/mvrm_datapath.sv
// ----------------------------------------------------------------------------
// mvrm_datapath
// sample memory, voice table, address wrap, divider and mix arithmetic
// ----------------------------------------------------------------------------
module mvrm_datapath #(
  parameter int VOICES       = mvrm_pkg::VOICES_DEF,
  parameter int SAMPLE_WORDS = mvrm_pkg::SAMPLE_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mvrm_pkg::dp_cmd_t                cmd,
  output mvrm_pkg::dp_sts_t                sts,
  input  logic [mvrm_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [mvrm_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                             cfg_valid,
  input  logic [mvrm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                      cfg_data,
  output logic [mvrm_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [mvrm_pkg::OUT_USER_W-1:0]  out_tuser
);
  import mvrm_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
  localparam longint unsigned RECIP = (64'd1 << 40) / SAMPLE_WORDS;
  localparam logic [30:0]   RECIP_K = 31'(RECIP);
  localparam logic [25:0]   SW_K    = 26'(SAMPLE_WORDS);
  localparam logic [VW-1:0] LAST_V  = VW'(VOICES - 1);

  // storage
  logic signed [15:0] smem [SAMPLE_WORDS];
  voice_t             vmem [VOICES];

  item_t              item_r;
  logic [2:0]         op_r;
  logic [15:0]        mvol_l_r, mvol_r_r;
  logic [VOICES-1:0]  active_r;
  logic [VW-1:0]      vidx_r;
  voice_t             vq_r;
  logic [16:0]        x_r;
  logic [7:0]         q_r;
  logic signed [15:0] smem_q_r, s0_r, s1_r;
  logic signed [29:0] p0_r, interp_r;
  logic [31:0]        gml_r, gmr_r;
  logic signed [62:0] prodl_r, prodr_r;
  logic signed [ACC_W-1:0] accl_r, accr_r;
  logic [19:0]        div_rem_r;
  logic [31:0]        div_q_r;
  logic [5:0]         div_cnt_r;
  logic               div_neg_r, div_nz_r;
  logic [31:0]        rampl_new_r;
  logic               status_r;
  logic [3:0]         granted_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_USER_W-1:0] out_tuser_r;

  // combinational
  logic [63:0]  act_pad;
  logic [15:0]  idx, nxt16;
  logic [16:0]  idx_p1;
  logic [11:0]  frac;
  logic [12:0]  w0;
  logic [47:0]  rprod;
  logic [25:0]  r0, rw;
  logic [AW-1:0] saddr;
  logic         free_found;
  logic [VW-1:0] free_idx;
  logic [VW-1:0] vrd_addr;
  logic [20:0]  rem_sh;
  logic         div_ge;
  logic signed [33:0] diff;
  logic [31:0]  ramp_calc;
  logic signed [32:0] qs;
  logic [28:0]  pos_n;
  logic [63:0]  adv_l, adv_r;
  logic         vwr_en;
  logic [VW-1:0] vwr_addr;
  voice_t       vwr_data;

  function automatic logic [63:0] gain_step(input logic [31:0] cur, input logic [15:0] goal,
                                            input logic [31:0] ramp);
    logic signed [33:0] c;
    logic signed [33:0] g;
    logic [31:0]        ramp_n;
    c      = $signed({2'b00, cur}) + 34'($signed(ramp));
    g      = $signed({2'b00, goal, 16'h0000});
    ramp_n = ramp;
    if (ramp == 32'd0) begin
      c = $signed({2'b00, cur});
    end else if ((!ramp[31] && c >= g) || (ramp[31] && c <= g)) begin
      c      = g;
      ramp_n = '0;
    end
    return {c[31:0], ramp_n};
  endfunction

  // round half up, then clamp to 16 bits
  function automatic logic [15:0] sat16(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    t = (acc + $signed(ACC_W'(32768))) >>> 16;
    if (t > $signed(ACC_W'(32767))) begin
      return 16'h7fff;
    end else if (t < -$signed(ACC_W'(32768))) begin
      return 16'h8000;
    end
    return t[15:0];
  endfunction

  assign act_pad = 64'(active_r);
  assign idx     = vq_r.position[27:12];
  assign frac    = vq_r.position[11:0];
  assign w0      = 13'd4096 - {1'b0, frac};
  assign idx_p1  = {1'b0, idx} + 17'd1;
  assign nxt16   = (idx_p1 < {1'b0, vq_r.length}) ? idx_p1[15:0] : idx;

  // address modulo the memory size: reciprocal estimate, one correction
  assign rprod = 48'(x_r) * 48'(RECIP_K);
  assign r0    = 26'(x_r) - 26'(q_r) * SW_K;
  assign rw    = (r0 >= SW_K) ? (r0 - SW_K) : r0;
  assign saddr = rw[AW-1:0];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (!free_found && !active_r[i]) begin
        free_found = 1'b1;
        free_idx   = VW'(i);
      end
    end
  end

  assign vrd_addr = (op_r == OP_TICK) ? vidx_r : VW'(item_r.voice_slot);

  assign sts.op         = op_r;
  assign sts.cur_active = act_pad[vidx_r];
  assign sts.past_end   = (idx >= vq_r.length);
  assign sts.last_voice = (vidx_r == LAST_V);
  assign sts.div_done   = (div_cnt_r == 6'd0);
  assign sts.slot_ok    = (32'(item_r.voice_slot) < VOICES) && act_pad[item_r.voice_slot];

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {div_rem_r, div_q_r[31]};
  assign div_ge = (rem_sh >= {1'b0, item_r.fade_samples});

  always_comb begin
    if (cmd.step == ST_DIVR_INIT) begin
      diff = $signed({2'b00, item_r.target_right, 16'h0000}) - $signed({2'b00, vq_r.cur_r});
    end else begin
      diff = $signed({2'b00, item_r.target_left, 16'h0000}) - $signed({2'b00, vq_r.cur_l});
    end
  end

  // truncated quotient, nudged one unit toward the goal when it is zero
  always_comb begin
    qs = div_neg_r ? -$signed({1'b0, div_q_r}) : $signed({1'b0, div_q_r});
    if (div_q_r == 32'd0 && div_nz_r) begin
      qs = div_neg_r ? -33'sd1 : 33'sd1;
    end
    ramp_calc = qs[31:0];
  end

  assign pos_n = {1'b0, vq_r.position} + 29'(vq_r.step);
  assign adv_l = gain_step(vq_r.cur_l, vq_r.goal_l, vq_r.ramp_l);
  assign adv_r = gain_step(vq_r.cur_r, vq_r.goal_r, vq_r.ramp_r);

  always_comb begin
    vwr_en   = 1'b0;
    vwr_addr = vrd_addr;
    vwr_data = vq_r;
    case (cmd.step)
      ST_START: begin
        vwr_en            = free_found;
        vwr_addr          = free_idx;
        vwr_data.start    = item_r.sample_address;
        vwr_data.length   = item_r.sound_length;
        vwr_data.position = '0;
        vwr_data.step     = UNITY_STEP;
        vwr_data.cur_l    = {UNITY_GAIN, 16'h0000};
        vwr_data.cur_r    = {UNITY_GAIN, 16'h0000};
        vwr_data.goal_l   = UNITY_GAIN;
        vwr_data.goal_r   = UNITY_GAIN;
        vwr_data.ramp_l   = '0;
        vwr_data.ramp_r   = '0;
      end
      ST_WB: begin
        vwr_en            = 1'b1;
        vwr_addr          = vidx_r;
        vwr_data.position = pos_n[27:0];
        vwr_data.cur_l    = adv_l[63:32];
        vwr_data.ramp_l   = adv_l[31:0];
        vwr_data.cur_r    = adv_r[63:32];
        vwr_data.ramp_r   = adv_r[31:0];
      end
      ST_VOL_WB: begin
        vwr_en          = 1'b1;
        vwr_data.goal_l = item_r.target_left;
        vwr_data.goal_r = item_r.target_right;
        if (item_r.fade_samples == 20'd0) begin
          vwr_data.cur_l  = {item_r.target_left, 16'h0000};
          vwr_data.cur_r  = {item_r.target_right, 16'h0000};
          vwr_data.ramp_l = '0;
          vwr_data.ramp_r = '0;
        end else begin
          vwr_data.ramp_l = rampl_new_r;
          vwr_data.ramp_r = ramp_calc;
        end
      end
      ST_PITCH_WB: begin
        vwr_en        = 1'b1;
        vwr_data.step = item_r.pitch_step;
      end
      default: vwr_en = 1'b0;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.step == ST_LOAD_WR) smem[saddr] <= item_r.sample_word;
    if (cmd.step == ST_SAMP0 || cmd.step == ST_SAMP1) smem_q_r <= smem[saddr];
  end

  always_ff @(posedge clk) begin
    if (vwr_en) vmem[vwr_addr] <= vwr_data;
    if (cmd.step == ST_VOICE_RD) vq_r <= vmem[vrd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      mvol_l_r  <= UNITY_GAIN;
      mvol_r_r  <= UNITY_GAIN;
      div_cnt_r <= '0;
      vidx_r    <= '0;
    end else begin
      if (cfg_valid && cfg_index == CFG_MASTER_L) mvol_l_r <= cfg_data;
      if (cfg_valid && cfg_index == CFG_MASTER_R) mvol_r_r <= cfg_data;
      case (cmd.step)
        ST_CAPTURE: vidx_r <= '0;
        ST_NEXT:    vidx_r <= vidx_r + 1'b1;
        ST_START: begin
          if (free_found) active_r[free_idx] <= 1'b1;
        end
        ST_CHECK: begin
          if (idx >= vq_r.length) active_r[vidx_r] <= 1'b0;
        end
        ST_WB: begin
          if (pos_n[28:12] >= {1'b0, vq_r.length}) active_r[vidx_r] <= 1'b0;
        end
        ST_DIVL_INIT, ST_DIVR_INIT: div_cnt_r <= 6'd32;
        ST_DIV_RUN: begin
          if (div_cnt_r != 6'd0) div_cnt_r <= div_cnt_r - 6'd1;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    q_r <= rprod[47:40];
    case (cmd.step)
      ST_CAPTURE: begin
        item_r    <= item_t'(in_tdata);
        op_r      <= in_tuser;
        x_r       <= {1'b0, in_tdata[19:4]};
        accl_r    <= '0;
        accr_r    <= '0;
        status_r  <= 1'b0;
        granted_r <= '0;
      end
      ST_START: begin
        status_r  <= !free_found;
        granted_r <= free_found ? 4'(free_idx) : 4'd0;
      end
      ST_CHECK: x_r <= {1'b0, vq_r.start} + {1'b0, idx};
      ST_SAMP0: x_r <= {1'b0, vq_r.start} + {1'b0, nxt16};
      ST_SAMP1: s0_r <= smem_q_r;
      ST_MIX0: begin
        p0_r  <= s0_r * $signed({1'b0, w0});
        s1_r  <= smem_q_r;
        gml_r <= vq_r.cur_l[31:16] * mvol_l_r;
      end
      ST_MIX1: begin
        interp_r <= p0_r + s1_r * $signed({1'b0, frac});
        gmr_r    <= vq_r.cur_r[31:16] * mvol_r_r;
      end
      ST_MUL_L: prodl_r <= interp_r * $signed({1'b0, gml_r});
      ST_MUL_R: begin
        prodr_r <= interp_r * $signed({1'b0, gmr_r});
        accl_r  <= accl_r + ACC_W'(prodl_r >>> 24);
      end
      ST_WB: accr_r <= accr_r + ACC_W'(prodr_r >>> 24);
      ST_DIVL_INIT, ST_DIVR_INIT: begin
        if (cmd.step == ST_DIVR_INIT) rampl_new_r <= ramp_calc;
        div_neg_r <= diff[33];
        div_nz_r  <= (diff != 34'sd0);
        div_q_r   <= diff[33] ? 32'(-diff) : diff[31:0];
        div_rem_r <= '0;
      end
      ST_DIV_RUN: begin
        if (div_cnt_r != 6'd0) begin
          div_rem_r <= div_ge ? 20'(rem_sh - {1'b0, item_r.fade_samples}) : rem_sh[19:0];
          div_q_r   <= {div_q_r[30:0], div_ge};
        end
      end
      ST_FINISH: begin
        out_tdata_r <= {4'b0000, act_pad[15:0], sat16(accr_r), sat16(accl_r), granted_r};
        out_tuser_r <= status_r;
      end
      default: ;
    endcase
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule

FILE: src/multi_voice_resampling_mixer_core.sv
// ----------------------------------------------------------------------------
// multi_voice_resampling_mixer_core
// wavetable stereo mixer with linear interpolation over a shared sample memory
// ----------------------------------------------------------------------------
// set volume runs two serial divider passes, left then right
// tick: visits every voice slot in turn and mixes each playing voice, paced by the
//   single sample memory read port and the shared multiplier steps per voice
// one item at a time; the next item is taken while the last result waits
// reset (rst_n low, synchronous) frees all voices and restores unity master
//   gains; sample memory and voice table keep their contents
module multi_voice_resampling_mixer_core #(
  parameter int VOICES       = mvrm_pkg::VOICES_DEF,
  parameter int SAMPLE_WORDS = mvrm_pkg::SAMPLE_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input item channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // voice_slot[3:0], sample_address[19:4], sample_word[35:20],
  // sound_length[51:36], target_left[67:52], target_right[83:68],
  // fade_samples[103:84], pitch_step[119:104]
  input  logic [mvrm_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation[2:0]
  input  logic [mvrm_pkg::IN_USER_W-1:0]  in_tuser,
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // granted_voice[3:0], left_sample[19:4], right_sample[35:20],
  // active_voices[51:36], zero fill [55:52]
  output logic [mvrm_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[0]
  output logic [mvrm_pkg::OUT_USER_W-1:0] out_tuser,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mvrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_data
);
  import mvrm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // master gains are plain registers, a write always lands at once
  assign cfg_ready = 1'b1;

  // sequencer: issues the datapath steps in order, with wait states for the address wrap
  mvrm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // voice table, sample memory, divider and mix arithmetic
  mvrm_datapath #(
    .VOICES       (VOICES),
    .SAMPLE_WORDS (SAMPLE_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

FILE: src/mvrm_checker.sv
// ----------------------------------------------------------------------------
// mvrm_checker
// port-level checks of the mixer core, bound to the top level
// ----------------------------------------------------------------------------
module mvrm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mvrm_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [mvrm_pkg::OUT_USER_W-1:0] out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one item in flight: a transfer closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // a refused start grants nothing
  a_refused_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[3:0] == 4'd0)
    else $error("grant on refused start");

  // a refused start mixes nothing
  a_refused_mix: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[35:4] == 32'd0)
    else $error("samples on refused start");

  // no result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind multi_voice_resampling_mixer_core mvrm_checker u_mvrm_checker (.*);
